// File: rtl/core/tgd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tgd_pkg;

   localparam int SAMPLE_W = 16;
   localparam int STAMP_W  = 32;
   localparam int VALUE_W  = 32;
   localparam int CODE_W   = 3;
   localparam int DELAY_W  = 16;
   localparam int MASK_W   = 5;
   localparam int INDEX_W  = 2;
   localparam int DATA_W   = 16;

   // register indexes on the configuration channel
   localparam logic [INDEX_W-1:0] REG_THRESHOLD = 2'd0;
   localparam logic [INDEX_W-1:0] REG_DBL_DELAY = 2'd1;
   localparam logic [INDEX_W-1:0] REG_LONG_DELAY = 2'd2;
   localparam logic [INDEX_W-1:0] REG_EVENT_MASK = 2'd3;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RST  = 16'd400;
   localparam logic [DELAY_W-1:0]  DBL_DELAY_RST  = 16'd300;
   localparam logic [DELAY_W-1:0]  LONG_DELAY_RST = 16'd1000;
   localparam logic [MASK_W-1:0]   EVENT_MASK_RST = 5'd31;

   typedef enum logic [CODE_W-1:0] {
      EV_DOWN   = 3'd0,
      EV_UP     = 3'd1,
      EV_CLICK  = 3'd2,
      EV_DOUBLE = 3'd3,
      EV_LONG   = 3'd4
   } code_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] touch_threshold;
      logic [DELAY_W-1:0]  double_click_delay;
      logic [DELAY_W-1:0]  long_press_delay;
      logic [MASK_W-1:0]   event_enable_mask;
   } cfg_type;

   typedef struct packed {
      code_type            code;
      logic [VALUE_W-1:0]  value;
   } event_type;

   // events raised by one sample, already compacted: slot 0 first
   typedef struct packed {
      logic [1:0]          count;
      event_type           slot1;
      event_type           slot0;
      logic                touched;
   } batch_type;

endpackage

`default_nettype wire

// File: rtl/core/tgd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tgd_req_if;
   logic                          valid;
   logic                          ready;
   logic [tgd_pkg::SAMPLE_W-1:0]  sample_value;
   logic [tgd_pkg::STAMP_W-1:0]   time_ms;

   modport source (output valid, sample_value, time_ms, input ready);
   modport sink   (input valid, sample_value, time_ms, output ready);
endinterface

interface tgd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tgd_pkg::CODE_W-1:0]    event_code;
   logic [tgd_pkg::VALUE_W-1:0]   event_value;
   logic                          touched_now;
   logic                          last_of_run;

   modport source (output valid, event_code, event_value, touched_now, last_of_run,
                   input ready);
   modport sink   (input valid, event_code, event_value, touched_now, last_of_run,
                   output ready);
endinterface

interface tgd_csr_if;
   logic                          valid;
   logic                          ready;
   logic [tgd_pkg::INDEX_W-1:0]   index;
   logic [tgd_pkg::DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tgd_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module tgd_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   tgd_csr_if.sink          csr_chan,
   output tgd_pkg::cfg_type cfg
);

   tgd_pkg::cfg_type cfg_ff;
   tgd_pkg::cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            tgd_pkg::REG_THRESHOLD:  cfg_in.touch_threshold    = csr_chan.data;
            tgd_pkg::REG_DBL_DELAY:  cfg_in.double_click_delay = csr_chan.data;
            tgd_pkg::REG_LONG_DELAY: cfg_in.long_press_delay   = csr_chan.data;
            tgd_pkg::REG_EVENT_MASK: begin
               cfg_in.event_enable_mask = csr_chan.data[tgd_pkg::MASK_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.touch_threshold    <= tgd_pkg::THRESHOLD_RST;
         cfg_ff.double_click_delay <= tgd_pkg::DBL_DELAY_RST;
         cfg_ff.long_press_delay   <= tgd_pkg::LONG_DELAY_RST;
         cfg_ff.event_enable_mask  <= tgd_pkg::EVENT_MASK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/tgd_core.sv
`timescale 1ns / 1ps
`default_nettype none

module tgd_core #(
   parameter int TIME_WIDTH  = 32,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   tgd_req_if.sink            req_chan,
   input  tgd_pkg::cfg_type   cfg,
   input  wire logic          can_load,
   output wire logic          load,
   output tgd_pkg::batch_type batch
);

   // input register
   logic                         in_valid_ff, in_valid_in;
   logic [tgd_pkg::SAMPLE_W-1:0] sample_ff;
   logic [tgd_pkg::STAMP_W-1:0]  stamp_ff;

   // gesture state
   logic                   last_touched_ff, last_touched_in;
   logic [COUNT_WIDTH-1:0] since_edge_ff, since_edge_in;
   logic                   click_pending_ff, click_pending_in;
   logic [TIME_WIDTH-1:0]  click_start_ff, click_start_in;
   logic [COUNT_WIDTH-1:0] click_count_ff, click_count_in;
   logic                   hold_armed_ff, hold_armed_in;
   logic [TIME_WIDTH-1:0]  hold_mark_ff, hold_mark_in;

   logic                   advance;
   logic                   touched;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic [TIME_WIDTH-1:0]  now;
   logic [TIME_WIDTH-1:0]  click_dt;
   logic [TIME_WIDTH-1:0]  hold_dt;
   logic [63:0]            hold_dt_ext;
   logic                   click_due;
   logic                   hold_due;
   logic                   a_raise, b_raise, a_en, b_en;
   tgd_pkg::event_type     ev_a, ev_b;

   assign advance        = in_valid_ff && can_load;
   assign load           = advance;
   assign req_chan.ready = !in_valid_ff || can_load;
   assign in_valid_in    = req_chan.valid ? 1'b1 : (in_valid_ff && !advance);

   assign touched   = sample_ff <= cfg.touch_threshold;
   assign count_inc = (since_edge_ff != '1) ? since_edge_ff + 1'b1 : since_edge_ff;
   assign now       = TIME_WIDTH'(stamp_ff);
   assign click_dt  = now - click_start_ff;
   assign hold_dt   = now - hold_mark_ff;
   assign hold_dt_ext = 64'(hold_dt);
   assign click_due = click_pending_ff && (click_dt >= TIME_WIDTH'(cfg.double_click_delay));
   assign hold_due  = touched && hold_armed_ff &&
                      (hold_dt >= TIME_WIDTH'(cfg.long_press_delay));

   always_comb begin
      last_touched_in  = last_touched_ff;
      since_edge_in    = count_inc;
      click_pending_in = click_pending_ff;
      click_start_in   = click_start_ff;
      click_count_in   = click_count_ff;
      hold_armed_in    = hold_armed_ff;
      hold_mark_in     = hold_mark_ff;
      a_raise          = 1'b0;
      b_raise          = 1'b0;
      ev_a.code        = tgd_pkg::EV_DOWN;
      ev_a.value       = 32'(count_inc);
      ev_b.code        = tgd_pkg::EV_CLICK;
      ev_b.value       = 32'(click_count_ff);

      if (touched != last_touched_ff) begin
         // edge: report it, then resolve the pending click
         a_raise   = 1'b1;
         ev_a.code = touched ? tgd_pkg::EV_DOWN : tgd_pkg::EV_UP;
         if (click_pending_ff && touched && !click_due) begin
            b_raise          = 1'b1;
            ev_b.code        = tgd_pkg::EV_DOUBLE;
            ev_b.value       = 32'(count_inc);
            click_pending_in = 1'b0;
         end else begin
            if (click_due) begin
               b_raise          = 1'b1;
               click_pending_in = 1'b0;
            end
            if (touched) begin
               click_start_in   = now;
               click_pending_in = 1'b1;
               click_count_in   = count_inc;
            end
         end
         if (touched) begin
            hold_armed_in = 1'b1;
            hold_mark_in  = now;
         end
         since_edge_in   = '0;
         last_touched_in = touched;
      end else begin
         ev_a.code  = tgd_pkg::EV_CLICK;
         ev_a.value = 32'(click_count_ff);
         if (click_due) begin
            a_raise          = 1'b1;
            click_pending_in = 1'b0;
         end
         ev_b.code  = tgd_pkg::EV_LONG;
         ev_b.value = hold_dt_ext[31:0];
         if (hold_due) begin
            b_raise      = 1'b1;
            hold_mark_in = now;
         end
      end
   end

   // masked events still take their state updates above; drop them here
   assign a_en = a_raise && cfg.event_enable_mask[ev_a.code];
   assign b_en = b_raise && cfg.event_enable_mask[ev_b.code];

   always_comb begin
      batch.count   = {1'b0, a_en} + {1'b0, b_en};
      batch.slot0   = a_en ? ev_a : ev_b;
      batch.slot1   = ev_b;
      batch.touched = touched;
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         sample_ff <= req_chan.sample_value;
         stamp_ff  <= req_chan.time_ms;
      end
      if (reset) begin
         in_valid_ff      <= 1'b0;
         last_touched_ff  <= 1'b0;
         since_edge_ff    <= '0;
         click_pending_ff <= 1'b0;
         click_start_ff   <= '0;
         click_count_ff   <= '0;
         hold_armed_ff    <= 1'b0;
         hold_mark_ff     <= '0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= in_valid_in;
         end
         if (advance) begin
            last_touched_ff  <= last_touched_in;
            since_edge_ff    <= since_edge_in;
            click_pending_ff <= click_pending_in;
            click_start_ff   <= click_start_in;
            click_count_ff   <= click_count_in;
            hold_armed_ff    <= hold_armed_in;
            hold_mark_ff     <= hold_mark_in;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/tgd_evbuf.sv
`timescale 1ns / 1ps
`default_nettype none

module tgd_evbuf (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          load,
   input  tgd_pkg::batch_type batch,
   output wire logic          can_load,
   tgd_rsp_if.source          rsp_chan
);

   logic [1:0]         fill_ff, fill_in;
   tgd_pkg::event_type head_ff, head_in;
   tgd_pkg::event_type tail_ff, tail_in;
   logic               touched_ff, touched_in;
   logic               pop;

   assign pop      = rsp_chan.valid && rsp_chan.ready;
   assign can_load = (fill_ff == 2'd0) || ((fill_ff == 2'd1) && rsp_chan.ready);

   assign rsp_chan.valid       = fill_ff != 2'd0;
   assign rsp_chan.event_code  = head_ff.code;
   assign rsp_chan.event_value = head_ff.value;
   assign rsp_chan.touched_now = touched_ff;
   assign rsp_chan.last_of_run = fill_ff == 2'd1;

   always_comb begin
      fill_in    = fill_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      touched_in = touched_ff;
      if (load) begin
         fill_in    = batch.count;
         head_in    = batch.slot0;
         tail_in    = batch.slot1;
         touched_in = batch.touched;
      end else if (pop) begin
         fill_in = fill_ff - 2'd1;
         head_in = tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      head_ff    <= head_in;
      tail_ff    <= tail_in;
      touched_ff <= touched_in;
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/touch_gesture_detector.sv
`timescale 1ns / 1ps
`default_nettype none

// Touch gesture detector. Each req transaction carries one filtered touch
// sample and its millisecond timestamp; a sample at or below touch_threshold
// counts as touched. Each sample gives zero, one or two rsp transactions in
// the order down/up, then double click or a delayed click, or while held a
// long press with the elapsed milliseconds; last_of_run marks the final one
// of a sample and touched_now gives the touch state after it. A sample that
// raises nothing gives no rsp transaction at all. Timing: a sample is held
// in the input register until the event buffer can take it, is evaluated in
// a single pass and lands in a two-entry event buffer, from whose head its
// first event is offered. The event buffer drains one event per cycle while
// rsp_chan.ready is high, and takes the events of the next sample as the last
// event of the previous one goes out. Events cleared in event_enable_mask are
// dropped but still update the gesture state. Write configuration only while
// no transaction is in flight; register writes take effect on the next
// cycle.
module touch_gesture_detector #(
   parameter int TIME_WIDTH  = 32,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   tgd_req_if.sink   req_chan,
   tgd_rsp_if.source rsp_chan,
   tgd_csr_if.sink   csr_chan
);

   tgd_pkg::cfg_type   cfg;
   tgd_pkg::batch_type batch;
   logic               can_load;
   logic               load;

   // hold the configuration registers
   tgd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // register the sample, evaluate it and advance the gesture state
   tgd_core #(
      .TIME_WIDTH  (TIME_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cfg      (cfg),
      .can_load (can_load),
      .load     (load),
      .batch    (batch)
   );

   // serialise the events of one sample onto the result channel
   tgd_evbuf u_evbuf (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .batch    (batch),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
